@@ sv/sbsm_pkg.sv @@
// shared types and constants for the serial bank switch mapper
// no dependencies
package sbsm_pkg;

  localparam int PRG_OFFSET_BITS = 18;
  localparam int CHR_OFFSET_BITS = 17;
  localparam int OFFSET_W        = 18;

  localparam logic [1:0] CMD_CPU_RD = 2'd0;
  localparam logic [1:0] CMD_CPU_WR = 2'd1;
  localparam logic [1:0] CMD_PPU_RD = 2'd2;
  localparam logic [1:0] CMD_PPU_WR = 2'd3;

  localparam logic [1:0] TGT_NONE    = 2'd0;
  localparam logic [1:0] TGT_PRG_ROM = 2'd1;
  localparam logic [1:0] TGT_PRG_RAM = 2'd2;
  localparam logic [1:0] TGT_CHR     = 2'd3;

  localparam logic [1:0] CFG_PRG_LOG2    = 2'd0;
  localparam logic [1:0] CFG_CHR_LOG2    = 2'd1;
  localparam logic [1:0] CFG_CHR_PRESENT = 2'd2;

  localparam logic [1:0] SEL_CTRL   = 2'd0;
  localparam logic [1:0] SEL_CHR_LO = 2'd1;
  localparam logic [1:0] SEL_CHR_HI = 2'd2;
  localparam logic [1:0] SEL_PRG    = 2'd3;

  localparam logic [4:0] SHIFT_EMPTY = 5'h10;
  localparam logic [4:0] CTRL_RESET  = 5'h0C;

  typedef struct packed {
    logic [2:0] prg_log2;
    logic [2:0] chr_log2;
    logic       chr_present;
  } sbsm_cfg_t;

  typedef struct packed {
    logic [4:0] ctrl;
    logic [4:0] chr_lo;
    logic [4:0] chr_hi;
    logic [3:0] prg_sel;
  } sbsm_banks_t;

endpackage

@@ sv/sbsm_serial.sv @@
// serial load shift register and the four bank/control registers
// depends on sbsm_pkg
module sbsm_serial (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  logic [15:0]         addr_i,
  input  logic [7:0]          data_i,
  output sbsm_pkg::sbsm_banks_t banks_o,
  output logic [1:0]          mirror_next_o
);
  import sbsm_pkg::*;

  logic [4:0]  shift_q, shift_d;
  sbsm_banks_t banks_q, banks_d;
  logic [4:0]  shifted;

  always_comb begin
    shift_d = shift_q;
    banks_d = banks_q;
    shifted = {data_i[0], shift_q[4:1]};
    if (wr_i) begin
      if (data_i[7]) begin
        shift_d = SHIFT_EMPTY;
        banks_d.ctrl = banks_q.ctrl | CTRL_RESET;
      end else if (shift_q[0]) begin
        shift_d = SHIFT_EMPTY;
        case (addr_i[14:13])
          SEL_CTRL:   banks_d.ctrl = shifted;
          SEL_CHR_LO: banks_d.chr_lo = shifted;
          SEL_CHR_HI: banks_d.chr_hi = shifted;
          default:    banks_d.prg_sel = shifted[3:0];
        endcase
      end else begin
        shift_d = shifted;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= SHIFT_EMPTY;
      banks_q <= '{ctrl: CTRL_RESET, chr_lo: '0, chr_hi: '0, prg_sel: '0};
    end else begin
      shift_q <= shift_d;
      banks_q <= banks_d;
    end
  end

  assign banks_o       = banks_q;
  assign mirror_next_o = banks_d.ctrl[1:0];

`ifndef SYNTHESIS
  a_reset_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i && data_i[7] |=> shift_q == SHIFT_EMPTY && banks_q.ctrl[3:2] == 2'b11)
    else $error("reset write did not clear shift register");
  a_shift_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_q != 5'h00)
    else $error("shift register lost its marker bit");
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_i |=> $stable(banks_q) && $stable(shift_q))
    else $error("bank state changed without a write");
`endif

endmodule

@@ sv/sbsm_translate.sv @@
// address translation for cpu and ppu accesses
// depends on sbsm_pkg
module sbsm_translate (
  input  logic [1:0]            cmd_i,
  input  logic [15:0]           addr_i,
  input  logic [7:0]            data_i,
  input  sbsm_pkg::sbsm_cfg_t   cfg_i,
  input  sbsm_pkg::sbsm_banks_t banks_i,
  output logic [1:0]            target_o,
  output logic [sbsm_pkg::OFFSET_W-1:0] offset_o,
  output logic                  we_o,
  output logic [7:0]            wdata_o
);
  import sbsm_pkg::*;

  localparam int PB = PRG_OFFSET_BITS;
  localparam int CB = CHR_OFFSET_BITS;
  localparam logic [2:0] PRG_LOG2_MAX = 3'(PB - 14);
  localparam logic [2:0] CHR_LOG2_MAX = 3'(CB - 12);

  logic [2:0]    prg_lg, chr_lg;
  logic [4:0]    prg_sh, chr_sh;
  logic [PB-1:0] prg_mask, prg_last, prg_bank16, prg_base, prg_off;
  logic [CB-1:0] chr_mask, chr_base, chr_lo_off, chr_off;

  always_comb begin
    prg_lg     = (cfg_i.prg_log2 > PRG_LOG2_MAX) ? PRG_LOG2_MAX : cfg_i.prg_log2;
    prg_sh     = {2'b00, prg_lg} + 5'd14;
    prg_mask   = ~({PB{1'b1}} << prg_sh);
    prg_last   = prg_mask - PB'(14'h3FFF);
    prg_bank16 = PB'({banks_i.prg_sel, 14'h0000});
    case (banks_i.ctrl[3:2])
      2'd0, 2'd1: begin
        prg_base = prg_bank16 & ~PB'(16'h4000) & prg_mask;
      end
      2'd2: begin
        prg_base = addr_i[14] ? prg_bank16 : '0;
      end
      default: begin
        prg_base = addr_i[14] ? prg_last : prg_bank16;
      end
    endcase
    if (banks_i.ctrl[3])
      prg_off = (prg_base + PB'(addr_i[13:0])) & prg_mask;
    else
      prg_off = (prg_base + PB'(addr_i[14:0])) & prg_mask;
  end

  always_comb begin
    chr_lg     = (cfg_i.chr_log2 > CHR_LOG2_MAX) ? CHR_LOG2_MAX : cfg_i.chr_log2;
    chr_sh     = {2'b00, chr_lg} + 5'd12;
    chr_mask   = ~({CB{1'b1}} << chr_sh);
    chr_lo_off = CB'(addr_i[11:0]);
    if (!banks_i.ctrl[4])
      chr_base = CB'({banks_i.chr_lo & 5'h1E, 12'h000}) + CB'(addr_i[12:0]);
    else if (addr_i[15:12] == 4'h0)
      chr_base = CB'({banks_i.chr_lo, 12'h000}) + chr_lo_off;
    else
      chr_base = CB'({banks_i.chr_hi, 12'h000}) + chr_lo_off;
    chr_off = cfg_i.chr_present ? (chr_base & chr_mask) : '0;
  end

  always_comb begin
    target_o = TGT_NONE;
    offset_o = '0;
    we_o     = 1'b0;
    wdata_o  = '0;
    if (cmd_i == CMD_CPU_RD || cmd_i == CMD_CPU_WR) begin
      if (addr_i[15:13] == 3'b011) begin
        target_o = TGT_PRG_RAM;
        offset_o = OFFSET_W'(addr_i[12:0]);
        if (cmd_i == CMD_CPU_WR) begin
          we_o    = 1'b1;
          wdata_o = data_i;
        end
      end else if (addr_i[15] && cmd_i == CMD_CPU_RD) begin
        target_o = TGT_PRG_ROM;
        offset_o = OFFSET_W'(prg_off);
      end
    end else begin
      target_o = TGT_CHR;
      offset_o = OFFSET_W'(chr_off);
      if (cmd_i == CMD_PPU_WR) begin
        we_o    = 1'b1;
        wdata_o = data_i;
      end
    end
  end

endmodule

@@ sv/serial_bank_switch_mapper_core.sv @@
// serial bank switch mapper top level: input register, translation, result register
// one word per cycle sustained while the result register is not stalled
// the input register and the bank state feed the result register combinationally
// reset clears valid flags, bank state and size registers to their defaults
// depends on sbsm_pkg, sbsm_serial, sbsm_translate
module serial_bank_switch_mapper_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [2:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  target_o,
  output logic [sbsm_pkg::OFFSET_W-1:0] offset_o,
  output logic        write_enable_o,
  output logic [7:0]  write_data_o,
  output logic [1:0]  mirroring_o
);
  import sbsm_pkg::*;

  sbsm_cfg_t   cfg_q;
  sbsm_banks_t banks;
  logic        s1_valid_q, out_valid_q;
  logic [1:0]  cmd_q;
  logic [15:0] addr_q;
  logic [7:0]  val_q;
  logic        s1_go, serial_wr;
  logic [1:0]  tgt_d, mirror_d;
  logic [OFFSET_W-1:0] off_d;
  logic        we_d;
  logic [7:0]  wdata_d;
  logic [1:0]  target_q, mirror_q;
  logic [OFFSET_W-1:0] offset_q;
  logic        we_q;
  logic [7:0]  wdata_q;

  assign s1_go      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign serial_wr  = s1_go && cmd_q == CMD_CPU_WR && addr_q[15];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{prg_log2: 3'd1, chr_log2: 3'd1, chr_present: 1'b1};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRG_LOG2:    cfg_q.prg_log2 <= cfg_data_i;
        CFG_CHR_LOG2:    cfg_q.chr_log2 <= cfg_data_i;
        CFG_CHR_PRESENT: cfg_q.chr_present <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (s1_go) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= command_i;
      addr_q <= address_i;
      val_q  <= value_i;
    end
    if (s1_go) begin
      target_q <= tgt_d;
      offset_q <= off_d;
      we_q     <= we_d;
      wdata_q  <= wdata_d;
      mirror_q <= mirror_d;
    end
  end

  sbsm_serial u_serial (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_i          (serial_wr),
    .addr_i        (addr_q),
    .data_i        (val_q),
    .banks_o       (banks),
    .mirror_next_o (mirror_d)
  );

  sbsm_translate u_translate (
    .cmd_i    (cmd_q),
    .addr_i   (addr_q),
    .data_i   (val_q),
    .cfg_i    (cfg_q),
    .banks_i  (banks),
    .target_o (tgt_d),
    .offset_o (off_d),
    .we_o     (we_d),
    .wdata_o  (wdata_d)
  );

  assign out_valid_o    = out_valid_q;
  assign target_o       = target_q;
  assign offset_o       = offset_q;
  assign write_enable_o = we_q;
  assign write_data_o   = wdata_q;
  assign mirroring_o    = mirror_q;

`ifndef SYNTHESIS
  a_we_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_enable_o |-> target_o == TGT_PRG_RAM || target_o == TGT_CHR)
    else $error("write word aimed at no memory");
  a_ram_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && target_o == TGT_PRG_RAM |-> offset_o[OFFSET_W-1:13] == '0)
    else $error("prg ram offset out of range");
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled with room in the pipeline");
`endif

endmodule

@@ verif/serial_bank_switch_mapper_core_test.sv @@
// self-checking testbench for serial_bank_switch_mapper_core: random bus words with random
// handshake gaps, every result word compared against an in-bench mapper model
// depends on sbsm_pkg and the rtl of serial_bank_switch_mapper_core
`timescale 1ns / 1ps

module serial_bank_switch_mapper_core_test;
  import sbsm_pkg::*;

  localparam logic [1:0] PRG_FIX_FIRST = 2'd2;
  localparam logic [7:0] SERIAL_CLEAR  = 8'h80;
  localparam int unsigned HOLD_CYCLES  = 150;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  data;
  } bus_word_t;

  typedef struct packed {
    logic [1:0]          target;
    logic [OFFSET_W-1:0] offset;
    logic                wr_en;
    logic [7:0]          wr_data;
    logic [1:0]          mirroring;
  } landing_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = CFG_PRG_LOG2;
  logic [2:0]          cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [1:0]          command_i = CMD_CPU_RD;
  logic [15:0]         address_i = '0;
  logic [7:0]          value_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [1:0]          target_o;
  logic [OFFSET_W-1:0] offset_o;
  logic                write_enable_o;
  logic [7:0]          write_data_o;
  logic [1:0]          mirroring_o;

  // mapper model state
  sbsm_cfg_t   sizes = '{prg_log2: 3'd1, chr_log2: 3'd1, chr_present: 1'b1};
  sbsm_banks_t bank_regs = '{ctrl: CTRL_RESET, chr_lo: '0, chr_hi: '0, prg_sel: '0};
  logic [4:0]  load_sr = SHIFT_EMPTY;

  bus_word_t   bus_words[$];
  landing_t    landings_due[$];
  int unsigned words_queued = 0;
  int unsigned landings_seen = 0;
  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  logic        quiet = 1'b0;
  logic        rx_hold = 1'b0;

  serial_bank_switch_mapper_core i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .command_i,
    .address_i,
    .value_i,
    .out_valid_o,
    .out_ready_i,
    .target_o,
    .offset_o,
    .write_enable_o,
    .write_data_o,
    .mirroring_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [OFFSET_W-1:0] prg_rom_off(logic [15:0] addr);
    int unsigned lg, mask, bank16, last, off;
    lg = (sizes.prg_log2 > PRG_OFFSET_BITS - 14) ? PRG_OFFSET_BITS - 14 : sizes.prg_log2;
    mask = (32'h4000 << lg) - 1;
    bank16 = bank_regs.prg_sel * 32'h4000;
    last = mask + 1 - 32'h4000;
    if (bank_regs.ctrl[3:2] < PRG_FIX_FIRST) begin
      off = ((bank16 & ~32'h4000) & mask) + (addr & 16'h7FFF);
    end else if (bank_regs.ctrl[3:2] == PRG_FIX_FIRST) begin
      off = (addr < 16'hC000) ? (addr & 16'h3FFF) : bank16 + (addr & 16'h3FFF);
    end else begin
      off = (addr < 16'hC000) ? bank16 + (addr & 16'h3FFF) : last + (addr & 16'h3FFF);
    end
    return OFFSET_W'(off & mask);
  endfunction

  function automatic logic [OFFSET_W-1:0] chr_mem_off(logic [15:0] addr);
    int unsigned lg, mask, off;
    if (!sizes.chr_present) return '0;
    lg = (sizes.chr_log2 > CHR_OFFSET_BITS - 12) ? CHR_OFFSET_BITS - 12 : sizes.chr_log2;
    mask = (32'h1000 << lg) - 1;
    if (!bank_regs.ctrl[4]) begin
      off = ((bank_regs.chr_lo & 5'h1E) * 32'h1000) + (addr & 16'h1FFF);
    end else if (addr < 16'h1000) begin
      off = (bank_regs.chr_lo * 32'h1000) + (addr & 16'h0FFF);
    end else begin
      off = (bank_regs.chr_hi * 32'h1000) + (addr & 16'h0FFF);
    end
    return OFFSET_W'(off & mask);
  endfunction

  function automatic void shift_in(logic [15:0] addr, logic [7:0] data);
    logic       done;
    logic [4:0] v;
    if (data[7]) begin
      load_sr = SHIFT_EMPTY;
      bank_regs.ctrl = bank_regs.ctrl | CTRL_RESET;
      return;
    end
    done = load_sr[0];
    load_sr = {data[0], load_sr[4:1]};
    if (!done) return;
    v = load_sr;
    load_sr = SHIFT_EMPTY;
    case (addr[14:13])
      SEL_CTRL:   bank_regs.ctrl = v;
      SEL_CHR_LO: bank_regs.chr_lo = v;
      SEL_CHR_HI: bank_regs.chr_hi = v;
      default:    bank_regs.prg_sel = v[3:0];
    endcase
  endfunction

  function automatic landing_t land_access(bus_word_t w);
    landing_t r;
    r = '0;
    if (w.cmd == CMD_CPU_RD || w.cmd == CMD_CPU_WR) begin
      if (w.addr >= 16'h6000 && w.addr < 16'h8000) begin
        r.target = TGT_PRG_RAM;
        r.offset = OFFSET_W'(w.addr - 16'h6000);
        if (w.cmd == CMD_CPU_WR) begin
          r.wr_en = 1'b1;
          r.wr_data = w.data;
        end
      end else if (w.addr >= 16'h8000) begin
        if (w.cmd == CMD_CPU_WR) begin
          shift_in(w.addr, w.data);
        end else begin
          r.target = TGT_PRG_ROM;
          r.offset = prg_rom_off(w.addr);
        end
      end
    end else begin
      r.target = TGT_CHR;
      r.offset = chr_mem_off(w.addr);
      if (w.cmd == CMD_PPU_WR) begin
        r.wr_en = 1'b1;
        r.wr_data = w.data;
      end
    end
    r.mirroring = bank_regs.ctrl[1:0];
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_word(logic [1:0] cmd, logic [15:0] addr, logic [7:0] data);
    bus_words.push_back('{cmd: cmd, addr: addr, data: data});
    words_queued++;
  endfunction

  // five serial writes, lsb first, the last address picks the register; a clear write and other words may be mixed in
  function automatic void queue_serial_load(logic [1:0] sel, logic [4:0] v);
    if ($urandom_range(0, 4) != 0)
      queue_word(CMD_CPU_WR, 16'h8000 | 16'($urandom), SERIAL_CLEAR | 8'($urandom));
    for (int i = 0; i < 5; i++) begin
      if ($urandom_range(0, 4) == 0)
        queue_word($urandom_range(0, 1) ? CMD_PPU_WR : CMD_CPU_RD, 16'($urandom),
                   8'($urandom));
      if ($urandom_range(0, 49) == 0)
        queue_word(CMD_CPU_WR, 16'h8000 | 16'($urandom), SERIAL_CLEAR);
      queue_word(CMD_CPU_WR, (i == 4) ? {1'b1, sel, 13'($urandom)} : 16'h8000 | 16'($urandom),
                 {1'b0, 6'($urandom), v[i]});
    end
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task automatic wait_idle();
    while (landings_seen != words_queued) @(posedge clk_i);
  endtask

  task automatic program_sizes(logic [2:0] prg, logic [2:0] chr, logic present);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PRG_LOG2;
    cfg_data_i <= prg;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_CHR_LOG2;
    cfg_data_i <= chr;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_CHR_PRESENT;
    cfg_data_i <= {2'b00, present};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sizes = '{prg_log2: prg, chr_log2: chr, chr_present: present};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : sender
    bus_word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) landings_due.push_back(land_access({command_i, address_i, value_i}));
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (bus_words.size() != 0) begin
        w = bus_words.pop_front();
        command_i  <= w.cmd;
        address_i  <= w.addr;
        value_i    <= w.data;
        in_valid_i <= 1'b1;
        send_gap = quiet ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : receiver
    landing_t got, want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = '{target_o, offset_o, write_enable_o, write_data_o, mirroring_o};
        if (landings_due.size() == 0) begin
          report_mismatch($sformatf("word with no access pending, target %0d offset %0h",
                                    got.target, got.offset));
        end else begin
          want = landings_due.pop_front();
          landings_seen++;
          if (got.target !== want.target)
            report_mismatch($sformatf("target %0d, expected %0d", got.target, want.target));
          if (got.offset !== want.offset)
            report_mismatch($sformatf("offset %0h, expected %0h", got.offset, want.offset));
          if (got.wr_en !== want.wr_en)
            report_mismatch($sformatf("write_enable %0b, expected %0b", got.wr_en, want.wr_en));
          if (got.wr_data !== want.wr_data)
            report_mismatch($sformatf("write_data %0h, expected %0h", got.wr_data,
                                      want.wr_data));
          if (got.mirroring !== want.mirroring)
            report_mismatch($sformatf("mirroring %0d, expected %0d", got.mirroring,
                                      want.mirroring));
        end
        recv_stall = quiet ? 0 : pick_gap();
      end
      if (rx_hold) begin
        out_ready_i <= 1'b0;
      end else if (recv_stall != 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin : rx_hold_off
    for (int k = 0; k < 2; k++) begin
      wait (landings_seen >= 370 + k * 480);
      @(posedge clk_i);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      rx_hold <= 1'b0;
    end
  end

  initial begin : stimulus
    logic [2:0]  prg_plan[6];
    logic [2:0]  chr_plan[6];
    logic        present_plan[6];
    int unsigned phase_end;
    int unsigned region;
    logic [1:0]  cmd;
    logic [15:0] addr;
    prg_plan     = '{3'd1, 3'd0, 3'd4, 3'd7, 3'd2, 3'($urandom)};
    chr_plan     = '{3'd1, 3'd0, 3'd5, 3'd7, 3'd3, 3'($urandom)};
    present_plan = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'($urandom)};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    program_sizes(prg_plan[0], chr_plan[0], present_plan[0]);

    queue_word(CMD_CPU_RD, 16'h0000, 8'h00);
    queue_word(CMD_CPU_WR, 16'h5FFF, 8'hFF);
    queue_word(CMD_CPU_RD, 16'h6000, 8'h00);
    queue_word(CMD_CPU_WR, 16'h7FFF, 8'hA5);
    queue_word(CMD_CPU_RD, 16'h8000, 8'h00);
    queue_word(CMD_CPU_RD, 16'hFFFF, 8'hFF);
    queue_word(CMD_PPU_RD, 16'h0000, 8'h00);
    queue_word(CMD_PPU_WR, 16'h1FFF, 8'h5A);
    queue_word(CMD_PPU_RD, 16'hFFFF, 8'hFF);
    queue_word(CMD_CPU_WR, 16'h8000, SERIAL_CLEAR);
    queue_serial_load(SEL_CTRL, 5'h13);
    queue_word(CMD_PPU_RD, 16'h0FFF, 8'h00);
    queue_word(CMD_PPU_RD, 16'h1000, 8'h00);
    queue_word(CMD_CPU_RD, 16'hC000, 8'h00);
    queue_serial_load(SEL_PRG, 5'h1F);
    queue_word(CMD_CPU_RD, 16'hBFFF, 8'h00);

    for (int p = 0; p < 6; p++) begin
      if (p != 0) begin
        wait_idle();
        program_sizes(prg_plan[p], chr_plan[p], present_plan[p]);
      end
      quiet = ($urandom_range(0, 3) == 0);
      phase_end = 25 + (p + 1) * 240;
      while (words_queued < phase_end) begin
        if ($urandom_range(0, 99) < 20) begin
          queue_serial_load(2'($urandom), 5'($urandom));
        end else begin
          cmd = 2'($urandom);
          region = $urandom_range(0, 5);
          case (region)
            0:       addr = 16'($urandom);
            1:       addr = 16'($urandom_range(16'h0000, 16'h0FFF));
            2:       addr = 16'($urandom_range(16'h1000, 16'h5FFF));
            3:       addr = 16'($urandom_range(16'h6000, 16'h7FFF));
            4:       addr = 16'($urandom_range(16'h8000, 16'hBFFF));
            default: addr = 16'($urandom_range(16'hC000, 16'hFFFF));
          endcase
          queue_word(cmd, addr, 8'($urandom));
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
